### hdl/kwsm_pkg.sv
// Package for the k-way sorted merge: field widths, register and command codes,
// controller state type and the command/status structs between the modules.
// No dependencies.
package kwsm_pkg;

  // Fixed widths of the port fields
  localparam int SRC_W      = 3;
  localparam int KEY_W      = 32;
  localparam int PAY_W      = 32;
  localparam int SIU_W      = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 4;

  // Defaults for the top-level parameters
  localparam int SOURCES_DEF       = 8;
  localparam int KEY_WIDTH_DEF     = 32;
  localparam int PAYLOAD_WIDTH_DEF = 32;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SOURCES_IN_USE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY0_DESCENDING = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY0_NULLS_LAST = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY1_DESCENDING = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KEY1_NULLS_LAST = 3'd4;

  // Item commands
  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_END  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_DRAIN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [SIU_W-1:0] sources_in_use;
    logic             key0_descending;
    logic             key0_nulls_last;
    logic             key1_descending;
    logic             key1_nulls_last;
  } cfg_t;

  typedef struct packed {
    logic accept;     // take the item on the input ports
    logic scan_init;  // clear the running best, rewind the scan
    logic scan_step;  // read one head and advance
    logic emit;       // present the best head and free its slot
  } dp_cmd_t;

  typedef struct packed {
    logic merge_ready;  // every source in use holds a head or has ended, one is held
    logic scan_last;    // the scan address is the last source in use
  } dp_stat_t;

endpackage

### hdl/kwsm_ctrl.sv
// Controller of the k-way sorted merge: sequences check, scan and emit.
// Depends on kwsm_pkg.
module kwsm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  kwsm_pkg::dp_stat_t stat,
  output kwsm_pkg::dp_cmd_t  cmd,
  output logic              busy
);
  import kwsm_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = (state != ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (stat.merge_ready) begin
          cmd.scan_init = 1'b1;
          state_next    = ST_SCAN;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // last head read is compared in this cycle
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        cmd.emit   = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

### hdl/kwsm_dpath.sv
// Datapath of the k-way sorted merge: head memory, valid/ended flags,
// scan address, head comparator and running best. Depends on kwsm_pkg.
module kwsm_dpath #(
  parameter int SOURCES       = kwsm_pkg::SOURCES_DEF,
  parameter int KEY_WIDTH     = kwsm_pkg::KEY_WIDTH_DEF,
  parameter int PAYLOAD_WIDTH = kwsm_pkg::PAYLOAD_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  kwsm_pkg::cfg_t              cfg,
  input  kwsm_pkg::dp_cmd_t           cmd,
  output kwsm_pkg::dp_stat_t          stat,
  input  logic                        command,
  input  logic [kwsm_pkg::SRC_W-1:0]  source,
  input  logic [kwsm_pkg::KEY_W-1:0]  key0,
  input  logic                        key0_null,
  input  logic [kwsm_pkg::KEY_W-1:0]  key1,
  input  logic                        key1_null,
  input  logic [kwsm_pkg::PAY_W-1:0]  payload,
  output logic [kwsm_pkg::SRC_W-1:0]  out_source,
  output logic [kwsm_pkg::KEY_W-1:0]  out_key0,
  output logic                        out_key0_null,
  output logic [kwsm_pkg::KEY_W-1:0]  out_key1,
  output logic                        out_key1_null,
  output logic [kwsm_pkg::PAY_W-1:0]  out_payload
);
  import kwsm_pkg::*;

  localparam int IDX_W  = (SOURCES > 1) ? $clog2(SOURCES) : 1;
  localparam int CNT_W  = $clog2(SOURCES + 1);
  localparam int HEAD_W = 2 * KEY_WIDTH + 2 + PAYLOAD_WIDTH;
  localparam int EXT_W  = 64;

  typedef struct packed {
    logic [KEY_WIDTH-1:0]     k0;
    logic [KEY_WIDTH-1:0]     k1;
    logic                     n0;
    logic                     n1;
    logic [PAYLOAD_WIDTH-1:0] pay;
  } head_t;

  // {before, equal} for one key column
  function automatic logic [1:0] col_cmp(
    input logic [KEY_WIDTH-1:0] va,
    input logic                 na,
    input logic [KEY_WIDTH-1:0] vb,
    input logic                 nb,
    input logic                 desc,
    input logic                 nulls_last
  );
    logic [1:0] r;
    if (na && nb) begin
      r = 2'b01;
    end else if (na) begin
      r = {!nulls_last, 1'b0};
    end else if (nb) begin
      r = {nulls_last, 1'b0};
    end else if (va == vb) begin
      r = 2'b01;
    end else if (va < vb) begin
      r = {!desc, 1'b0};
    end else begin
      r = {desc, 1'b0};
    end
    return r;
  endfunction

  logic [SOURCES-1:0] head_valid;
  logic [SOURCES-1:0] source_ended;
  logic [SOURCES-1:0] in_use;
  logic [HEAD_W-1:0]  head_mem [SOURCES];

  logic [CNT_W-1:0] n_eff;
  logic [IDX_W-1:0] wr_idx;
  logic             src_in_use;
  logic             do_push;
  head_t            wr_head;

  logic [IDX_W-1:0]  scan_idx;
  logic [IDX_W-1:0]  rd_idx;
  logic              rd_vld;
  logic              cmp_en;
  logic [HEAD_W-1:0] rd_data;
  head_t             rd_head;

  logic             best_found;
  logic [IDX_W-1:0] best_idx;
  head_t            best;
  logic [1:0]       c0;
  logic [1:0]       c1;
  logic             rd_before;

  logic [EXT_W-1:0] k0_ext;
  logic [EXT_W-1:0] k1_ext;
  logic [EXT_W-1:0] pay_ext;

  // Effective source count: zero acts as one, clamp to SOURCES
  always_comb begin
    if (cfg.sources_in_use == '0) begin
      n_eff = CNT_W'(1);
    end else if (int'(cfg.sources_in_use) > SOURCES) begin
      n_eff = CNT_W'(SOURCES);
    end else begin
      n_eff = CNT_W'(cfg.sources_in_use);
    end
    for (int i = 0; i < SOURCES; i++) begin
      in_use[i] = (i < int'(n_eff));
    end
  end

  assign wr_idx     = IDX_W'(source);
  assign src_in_use = (int'(source) < int'(n_eff));
  assign do_push    = cmd.accept && src_in_use && (command == CMD_PUSH) &&
                      !source_ended[wr_idx];

  assign wr_head.k0  = KEY_WIDTH'(key0);
  assign wr_head.k1  = KEY_WIDTH'(key1);
  assign wr_head.n0  = key0_null;
  assign wr_head.n1  = key1_null;
  assign wr_head.pay = PAYLOAD_WIDTH'(payload);

  assign stat.merge_ready = (&(head_valid | source_ended | ~in_use)) &&
                            (|(head_valid & in_use));
  assign stat.scan_last   = ((CNT_W'(scan_idx) + CNT_W'(1)) == n_eff);

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid   <= '0;
      source_ended <= '0;
    end else begin
      if (cmd.accept && src_in_use) begin
        if (command == CMD_END) begin
          source_ended[wr_idx] <= 1'b1;
        end else if (!source_ended[wr_idx]) begin
          head_valid[wr_idx] <= 1'b1;
        end
      end
      if (cmd.emit) begin
        head_valid[best_idx] <= 1'b0;
      end
    end
  end

  // Head memory: write on push, registered read during the scan
  always_ff @(posedge clk) begin
    if (do_push) begin
      head_mem[wr_idx] <= wr_head;
    end
    rd_data <= head_mem[scan_idx];
  end

  assign rd_head = rd_data;

  always_ff @(posedge clk) begin
    rd_idx <= scan_idx;
    rd_vld <= head_valid[scan_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx <= '0;
      cmp_en   <= 1'b0;
    end else begin
      cmp_en <= cmd.scan_step;
      if (cmd.scan_init) begin
        scan_idx <= '0;
      end else if (cmd.scan_step) begin
        scan_idx <= scan_idx + IDX_W'(1);
      end
    end
  end

  always_comb begin
    c0 = col_cmp(rd_head.k0, rd_head.n0, best.k0, best.n0,
                 cfg.key0_descending, cfg.key0_nulls_last);
    c1 = col_cmp(rd_head.k1, rd_head.n1, best.k1, best.n1,
                 cfg.key1_descending, cfg.key1_nulls_last);
    // strict: on a full tie keep the lower index already held
    rd_before = c0[1] || (c0[0] && c1[1]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      best_found <= 1'b0;
    end else if (cmd.scan_init) begin
      best_found <= 1'b0;
    end else if (cmp_en && rd_vld) begin
      best_found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmp_en && rd_vld && (!best_found || rd_before)) begin
      best     <= rd_head;
      best_idx <= rd_idx;
    end
  end

  assign k0_ext  = EXT_W'(best.k0);
  assign k1_ext  = EXT_W'(best.k1);
  assign pay_ext = EXT_W'(best.pay);

  assign out_source    = SRC_W'(best_idx);
  assign out_key0      = k0_ext[KEY_W-1:0];
  assign out_key0_null = best.n0;
  assign out_key1      = k1_ext[KEY_W-1:0];
  assign out_key1_null = best.n1;
  assign out_payload   = pay_ext[PAY_W-1:0];

endmodule

### hdl/kway_sorted_merge.sv
// Top level of the k-way sorted merge: configuration registers, controller
// and datapath. Depends on kwsm_pkg, kwsm_ctrl and kwsm_dpath.
//
//  channel   handshake               fields
//  -------   ---------------------   ---------------------------------------
//  item in   start & !busy           command source key0 key0_null key1
//                                    key1_null payload
//  result    result_strobe (1 cycle) out_source out_key0 out_key0_null
//                                    out_key1 out_key1_null out_payload
//  config    cfg_valid & cfg_ready   cfg_index cfg_data
//
// An item that releases no result keeps busy high only in the check state.
// An item that releases a result keeps busy high through check, scan, drain and
// emit: the scan reads the heads of the n effective sources_in_use through the
// single read port of the head memory, drain compares, emit raises the strobe.
// Reset clears the valid and ended flags and loads the register defaults.
// The receiver cannot stall; cfg_ready is always high.
module kway_sorted_merge #(
  parameter int SOURCES       = kwsm_pkg::SOURCES_DEF,
  parameter int KEY_WIDTH     = kwsm_pkg::KEY_WIDTH_DEF,
  parameter int PAYLOAD_WIDTH = kwsm_pkg::PAYLOAD_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic                             command,
  input  logic [kwsm_pkg::SRC_W-1:0]       source,
  input  logic [kwsm_pkg::KEY_W-1:0]       key0,
  input  logic                             key0_null,
  input  logic [kwsm_pkg::KEY_W-1:0]       key1,
  input  logic                             key1_null,
  input  logic [kwsm_pkg::PAY_W-1:0]       payload,
  output logic                             result_strobe,
  output logic [kwsm_pkg::SRC_W-1:0]       out_source,
  output logic [kwsm_pkg::KEY_W-1:0]       out_key0,
  output logic                             out_key0_null,
  output logic [kwsm_pkg::KEY_W-1:0]       out_key1,
  output logic                             out_key1_null,
  output logic [kwsm_pkg::PAY_W-1:0]       out_payload,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [kwsm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [kwsm_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import kwsm_pkg::*;

  cfg_t     cfg;
  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sources_in_use  <= SIU_W'(8);
      cfg.key0_descending <= 1'b0;
      cfg.key0_nulls_last <= 1'b0;
      cfg.key1_descending <= 1'b0;
      cfg.key1_nulls_last <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SOURCES_IN_USE:  cfg.sources_in_use  <= cfg_data;
        REG_KEY0_DESCENDING: cfg.key0_descending <= cfg_data[0];
        REG_KEY0_NULLS_LAST: cfg.key0_nulls_last <= cfg_data[0];
        REG_KEY1_DESCENDING: cfg.key1_descending <= cfg_data[0];
        REG_KEY1_NULLS_LAST: cfg.key1_nulls_last <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  kwsm_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  kwsm_dpath #(
    .SOURCES       (SOURCES),
    .KEY_WIDTH     (KEY_WIDTH),
    .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .cmd           (cmd),
    .stat          (stat),
    .command       (command),
    .source        (source),
    .key0          (key0),
    .key0_null     (key0_null),
    .key1          (key1),
    .key1_null     (key1_null),
    .payload       (payload),
    .out_source    (out_source),
    .out_key0      (out_key0),
    .out_key0_null (out_key0_null),
    .out_key1      (out_key1),
    .out_key1_null (out_key1_null),
    .out_payload   (out_payload)
  );

  assign result_strobe = cmd.emit;

  // A result only comes out of a running merge, and frees the block after it
  a_strobe_busy: assert property (@(posedge clk) disable iff (rst)
    result_strobe |-> busy)
    else $error("result strobe while idle");

  a_strobe_release: assert property (@(posedge clk) disable iff (rst)
    result_strobe |=> !busy)
    else $error("busy held after a result");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !result_strobe))
    else $error("taken item did not start the merge check");

endmodule
